// ===== sv/ldl_pkg.sv =====
// shared constants, codes and types for the layer sorted display list
package ldl_pkg;

    localparam int NUM_BANKS  = 4;
    localparam int LIST_DEPTH = 64;
    localparam int PAYLOAD_W  = 48;
    localparam int LAYER_W    = 8;

    localparam int OP_W     = 3;
    localparam int BANK_W   = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = $clog2(LIST_DEPTH);
    localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
    localparam int BIDX_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_HANDLE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_POS    = 2'd3;

    typedef struct packed {
        logic [LAYER_W-1:0]   layer;
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic [BIDX_W-1:0] bank;
        t_entry            new_entry;
        logic [CNT_W-1:0]  cnt;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  hidx;
        logic              cmp_en;
        logic              ins_en;
        logic              rem_en;
    } t_cell_ctl;

endpackage

// ===== sv/layer_sorted_display_list_unit.sv =====
// top level: sorted display list banks built from a chain of slot cells
// flow: an accepted transaction passes the compare, encode and commit steps of
//   the slot chain, and the next is taken only once commit is done; a full
//   output register stalls commit
// reset: synchronous active low clears the sequencer, output valid and bank
//   counts; stored entries and handle map are unknown until written
module layer_sorted_display_list_unit import ldl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [BANK_W-1:0]    i_bank,
    input  logic [LAYER_W-1:0]   i_layer,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [PAYLOAD_W-1:0] i_payload,
    input  logic [CNT_W-1:0]     i_handle,
    input  logic [SLOT_W-1:0]    i_position,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [CNT_W-1:0]     o_new_handle,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [LAYER_W-1:0]   o_entry_layer,
    output logic [KIND_W-1:0]    o_entry_kind,
    output logic [PAYLOAD_W-1:0] o_entry_payload,
    output logic [CNT_W-1:0]     o_count
);

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;  // cells compare layers, handle map read
    localparam logic [1:0] S_ENC  = 2'd2;  // encode insertion slot or target slot
    localparam logic [1:0] S_CMT  = 2'd3;  // cells shift/write, result captured

    logic [1:0] r_state;

    // transaction registers
    logic [OP_W-1:0]      r_op;
    logic [BIDX_W-1:0]    r_bank;
    t_entry               r_new;
    logic [CNT_W-1:0]     r_handle;
    logic [SLOT_W-1:0]    r_position;
    logic [CNT_W-1:0]     r_cnt;
    logic [SLOT_W-1:0]    r_hsel;
    logic [SLOT_W-1:0]    r_slot;

    logic [CNT_W-1:0]     r_bank_cnt [NUM_BANKS];

    // chain signals between neighbor cells
    t_entry            w_ent   [LIST_DEPTH];
    logic              w_gt    [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_ins;
    logic [SLOT_W-1:0] w_hslot [LIST_DEPTH];
    t_entry            w_rde   [LIST_DEPTH];

    t_cell_ctl         w_ctl;
    logic              w_full;
    logic              w_hvalid;
    logic              w_pvalid;
    logic              w_out_free;
    logic              w_commit;
    logic              w_accept;
    logic [SLOT_W-1:0] w_hsel_or;
    logic [SLOT_W-1:0] w_pos;
    logic [SLOT_W-1:0] w_hslot_clamp;
    t_entry            w_rd;

    assign o_in_stall = r_state != S_IDLE;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_commit   = (r_state == S_CMT) && w_out_free;

    assign w_full   = r_cnt >= CNT_W'(LIST_DEPTH);
    assign w_hvalid = (r_handle != '0) && (r_handle <= r_cnt);
    assign w_pvalid = (CNT_W'(r_position) < r_cnt) && (CNT_W'(r_position) < CNT_W'(LIST_DEPTH));

    assign w_hslot_clamp = (CNT_W'(r_hsel) >= CNT_W'(LIST_DEPTH)) ?
                           SLOT_W'(LIST_DEPTH - 1) : r_hsel;

    always_comb begin
        w_ctl           = '0;
        w_ctl.bank      = r_bank;
        w_ctl.new_entry = r_new;
        w_ctl.cnt       = r_cnt;
        w_ctl.slot      = r_slot;
        w_ctl.hidx      = r_handle - 1'b1;
        w_ctl.cmp_en    = r_state == S_CMP;
        w_ctl.ins_en    = w_commit && (r_op == OP_INSERT) && !w_full;
        w_ctl.rem_en    = w_commit && (r_op == OP_REMOVE) && w_hvalid;
    end

    // the slot chain
    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        t_entry w_pe;
        logic   w_pg;
        if (k == 0) begin : g_first
            assign w_pe = '0;
            assign w_pg = 1'b0;
        end else begin : g_next
            assign w_pe = w_ent[k-1];
            assign w_pg = w_gt[k-1];
        end
        ldl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_idx        (CNT_W'(k)),
            .i_prev_entry (w_pe),
            .i_prev_gt    (w_pg),
            .o_entry      (w_ent[k]),
            .o_gt         (w_gt[k]),
            .o_ins        (w_ins[k]),
            .o_hslot      (w_hslot[k]),
            .o_rd_entry   (w_rde[k])
        );
    end

    // or-collect the one selected cell per reduction
    always_comb begin
        w_hsel_or = '0;
        w_pos     = '0;
        w_rd      = '0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            w_hsel_or = w_hsel_or | w_hslot[k];
            w_pos     = w_pos | (w_ins[k] ? SLOT_W'(k) : '0);
            w_rd      = w_rd | w_rde[k];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (w_accept) r_state <= S_CMP;
                S_CMP:   r_state <= S_ENC;
                S_ENC:   r_state <= S_CMT;
                S_CMT:   if (w_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // transaction capture and slot selection
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op          <= i_op;
            r_bank        <= BIDX_W'(i_bank % NUM_BANKS);
            r_new.layer   <= i_layer;
            r_new.kind    <= i_kind;
            r_new.payload <= i_payload;
            r_handle      <= i_handle;
            r_position    <= i_position;
            r_cnt         <= r_bank_cnt[BIDX_W'(i_bank % NUM_BANKS)];
        end
        if (r_state == S_CMP) begin
            r_hsel <= w_hsel_or;
        end
        if (r_state == S_ENC) begin
            case (r_op)
                OP_INSERT: r_slot <= w_pos;
                OP_READ:   r_slot <= r_position;
                default:   r_slot <= w_hslot_clamp;
            endcase
        end
    end

    // bank counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_bank_cnt[b] <= '0;
            end
        end else if (w_commit) begin
            if ((r_op == OP_INSERT) && !w_full) begin
                r_bank_cnt[r_bank] <= r_cnt + 1'b1;
            end else if (r_op == OP_CLEAR) begin
                r_bank_cnt[r_bank] <= '0;
            end
        end
    end

    // output register: one result transaction per input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_commit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            o_status        <= STAT_OK;
            o_new_handle    <= '0;
            o_slot          <= '0;
            o_entry_layer   <= '0;
            o_entry_kind    <= '0;
            o_entry_payload <= '0;
            o_count         <= r_cnt;
            case (r_op)
                OP_INSERT: begin
                    if (w_full) begin
                        o_status <= STAT_FULL;
                    end else begin
                        o_new_handle <= r_cnt + 1'b1;
                        o_slot       <= r_slot;
                        o_count      <= r_cnt + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!w_hvalid) begin
                        o_status <= STAT_BAD_HANDLE;
                    end else begin
                        o_slot <= r_slot;
                    end
                end
                OP_LOOKUP, OP_READ: begin
                    if ((r_op == OP_LOOKUP) && !w_hvalid) begin
                        o_status <= STAT_BAD_HANDLE;
                    end else if ((r_op == OP_READ) && !w_pvalid) begin
                        o_status <= STAT_BAD_POS;
                    end else begin
                        o_slot          <= r_slot;
                        o_entry_layer   <= w_rd.layer;
                        o_entry_kind    <= w_rd.kind;
                        o_entry_payload <= w_rd.payload;
                    end
                end
                OP_CLEAR: begin
                    o_count <= '0;
                end
                default: begin
                    o_count <= r_cnt;
                end
            endcase
        end
    end

    // a good insert grows its bank by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_op == OP_INSERT) && !w_full)
        |=> (r_bank_cnt[$past(r_bank)] == $past(r_cnt) + 1'b1))
        else $error("insert did not bump bank count");

    // sorted chain gives exactly one insertion point
    a_ins_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ENC) && (r_op == OP_INSERT) && !w_full) |-> $onehot(w_ins))
        else $error("insertion point not unique");

    // a handle is only handed out on a good insert
    a_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_new_handle != '0)) |-> (o_status == STAT_OK))
        else $error("new handle with error status");

    // captured count never exceeds the list depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt <= CNT_W'(LIST_DEPTH)))
        else $error("bank count out of range");

endmodule

// ===== sv/ldl_cell.sv =====
// one list slot of every bank: entry, handle map entry and insert compare
module ldl_cell import ldl_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CNT_W-1:0]  i_idx,
    input  t_entry            i_prev_entry,
    input  logic              i_prev_gt,
    output t_entry            o_entry,
    output logic              o_gt,
    output logic              o_ins,
    output logic [SLOT_W-1:0] o_hslot,
    output t_entry            o_rd_entry
);

    t_entry            r_ent [NUM_BANKS];
    logic [SLOT_W-1:0] r_h2s [NUM_BANKS];
    logic              r_gt;

    logic   w_below;
    logic   w_at_cnt;
    t_entry w_cur;

    assign w_cur    = r_ent[i_ctl.bank];
    assign w_below  = i_idx < i_ctl.cnt;
    assign w_at_cnt = i_idx == i_ctl.cnt;

    assign o_entry    = w_cur;
    assign o_gt       = r_gt;
    // insertion point: first slot whose layer is larger, or the top of the list
    assign o_ins      = !i_prev_gt && (r_gt || w_at_cnt);
    assign o_hslot    = (i_idx == i_ctl.hidx) ? r_h2s[i_ctl.bank] : '0;
    assign o_rd_entry = (i_idx == CNT_W'(i_ctl.slot)) ? w_cur : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_gt <= w_below && (i_ctl.new_entry.layer < w_cur.layer);
        end
        if (i_ctl.ins_en) begin
            if (i_prev_gt) begin
                r_ent[i_ctl.bank] <= i_prev_entry;
            end else if (o_ins) begin
                r_ent[i_ctl.bank] <= i_ctl.new_entry;
            end
            if (w_below && (r_h2s[i_ctl.bank] >= i_ctl.slot)) begin
                r_h2s[i_ctl.bank] <= r_h2s[i_ctl.bank] + 1'b1;
            end else if (w_at_cnt) begin
                r_h2s[i_ctl.bank] <= i_ctl.slot;
            end
        end
        if (i_ctl.rem_en && (i_idx == CNT_W'(i_ctl.slot))) begin
            r_ent[i_ctl.bank].kind <= '0;
        end
    end

endmodule
